// ----- hw/rtl/tile_max_point_picker_top_defines.svh -----
// Assertion macros for the tile max point picker.
// Used by the top level only; expect i_clk and i_rst_n in scope.
`ifndef TILE_MAX_POINT_PICKER_TOP_DEFINES_SVH
`define TILE_MAX_POINT_PICKER_TOP_DEFINES_SVH

// same-cycle implication
`define TMPP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tmpp assertion failed");

// next-cycle implication
`define TMPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tmpp assertion failed");

`endif

// ----- hw/rtl/tmpp_pkg.sv -----
// Shared types and constants for the tile max point picker.
// No dependencies.
package tmpp_pkg;

    localparam int MAX_TILES   = 256;
    localparam int TILE_IDX_W  = $clog2(MAX_TILES);
    localparam int COL_W       = TILE_IDX_W + 1;
    localparam int DIM_W       = 13;
    localparam int POS_W       = 12;
    localparam int TILE_W      = 7;
    localparam int TPOS_W      = 6;
    localparam int RESP_W      = 16;
    localparam int SCORE_W     = 15;
    localparam int CFG_IDX_W   = 2;

    localparam logic [DIM_W-1:0]  RESET_WIDTH  = 13'd512;
    localparam logic [DIM_W-1:0]  RESET_HEIGHT = 13'd512;
    localparam logic [TILE_W-1:0] RESET_TILE   = 7'd21;
    localparam logic [DIM_W-1:0]  DIM_MAX      = 13'd4096;
    localparam logic [TILE_W-1:0] TILE_MAX     = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_TILE   = 2'd2
    } t_cfg_idx;

    // last valid index of each dimension, after clamping
    typedef struct packed {
        logic [POS_W-1:0]  w_last;
        logic [POS_W-1:0]  h_last;
        logic [TPOS_W-1:0] ts_last;
    } t_cfg;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             col_ok;
        logic             first;
        logic             last;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_pix;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic emit;
    } t_s1_st;

endpackage

// ----- hw/rtl/tmpp_cfg.sv -----
// Configuration registers with clamping of the image and tile sizes.
// Depends on tmpp_pkg.
module tmpp_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [tmpp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tmpp_pkg::DIM_W-1:0]     i_cfg_data,
    output tmpp_pkg::t_cfg                 o_cfg
);
    import tmpp_pkg::*;

    logic [DIM_W-1:0]  r_width, r_height;
    logic [TILE_W-1:0] r_tile;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
            r_tile   <= RESET_TILE;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_TILE:   r_tile   <= i_cfg_data[TILE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    function automatic logic [POS_W-1:0] dim_last(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] m;
        if (d == '0)
            m = '0;
        else if (d > DIM_MAX)
            m = DIM_MAX - 1'b1;
        else
            m = d - 1'b1;
        return m[POS_W-1:0];
    endfunction

    always_comb begin
        logic [TILE_W-1:0] t;
        o_cfg.w_last = dim_last(r_width);
        o_cfg.h_last = dim_last(r_height);
        if (r_tile == '0)
            t = '0;
        else if (r_tile > TILE_MAX)
            t = TILE_MAX - 1'b1;
        else
            t = r_tile - 1'b1;
        o_cfg.ts_last = t[TPOS_W-1:0];
    end

endmodule

// ----- hw/rtl/tmpp_scan.sv -----
// Raster position counters: pixel, position in tile and tile column.
// Depends on tmpp_pkg.
module tmpp_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  tmpp_pkg::t_cfg i_cfg,
    output tmpp_pkg::t_pix o_pix
);
    import tmpp_pkg::*;

    logic [POS_W-1:0]  r_px, r_py, n_px, n_py;
    logic [TPOS_W-1:0] r_xt, r_yt, n_xt, n_yt;
    logic [COL_W-1:0]  r_col, n_col;
    logic              end_x, end_y, edge_x, edge_y;

    assign end_x  = r_px >= i_cfg.w_last;
    assign end_y  = r_py >= i_cfg.h_last;
    assign edge_x = r_xt >= i_cfg.ts_last;
    assign edge_y = r_yt >= i_cfg.ts_last;

    assign o_pix.col    = r_col;
    assign o_pix.col_ok = ~r_col[COL_W-1];
    assign o_pix.first  = (r_xt == '0) && (r_yt == '0);
    assign o_pix.last   = (end_x || edge_x) && (end_y || edge_y);
    assign o_pix.x      = r_px;
    assign o_pix.y      = r_py;

    always_comb begin
        n_px  = r_px;
        n_py  = r_py;
        n_xt  = r_xt;
        n_yt  = r_yt;
        n_col = r_col;
        if (end_x) begin
            n_px  = '0;
            n_xt  = '0;
            n_col = '0;
            if (end_y) begin
                n_py = '0;
                n_yt = '0;
            end else begin
                n_py = r_py + 1'b1;
                n_yt = edge_y ? '0 : r_yt + 1'b1;
            end
        end else begin
            n_px = r_px + 1'b1;
            if (edge_x) begin
                n_xt = '0;
                if (!r_col[COL_W-1]) n_col = r_col + 1'b1;
            end else begin
                n_xt = r_xt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px  <= '0;
            r_py  <= '0;
            r_xt  <= '0;
            r_yt  <= '0;
            r_col <= '0;
        end else if (i_accept) begin
            r_px  <= n_px;
            r_py  <= n_py;
            r_xt  <= n_xt;
            r_yt  <= n_yt;
            r_col <= n_col;
        end
    end

endmodule

// ----- hw/rtl/tmpp_tile.sv -----
// Per-tile-column best-point memory and its read-modify-write stage.
// Depends on tmpp_pkg.
module tmpp_tile (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  tmpp_pkg::t_pix              i_pix,
    input  logic [tmpp_pkg::RESP_W-1:0] i_resp,
    input  logic                        i_move,
    output tmpp_pkg::t_s1_st            o_st,
    output tmpp_pkg::t_entry            o_res
);
    import tmpp_pkg::*;

    t_entry              mem [MAX_TILES];
    logic [MAX_TILES-1:0] r_vld;

    logic                r_s1_valid;
    t_pix                r_s1_pix;
    logic [RESP_W-1:0]   r_s1_resp;
    t_entry              r_rd;
    logic                r_rd_vld;
    t_entry              r_fwd;
    logic                r_fwd_hit;

    t_entry              base, upd, wr_entry;
    logic                emit, wr_en;

    always_comb begin
        if (r_fwd_hit)
            base = r_fwd;
        else if (r_rd_vld)
            base = r_rd;
        else
            base = '0;
        if (r_s1_pix.first) base.score = '0;
        upd = base;
        if (!r_s1_resp[RESP_W-1] && (r_s1_resp[SCORE_W-1:0] > base.score)) begin
            upd.score = r_s1_resp[SCORE_W-1:0];
            upd.x     = r_s1_pix.x;
            upd.y     = r_s1_pix.y;
        end
        emit     = r_s1_pix.col_ok && r_s1_pix.last && (upd.score != '0);
        wr_entry = upd;
        if (emit) wr_entry.score = '0;
    end

    assign wr_en      = r_s1_valid && i_move && r_s1_pix.col_ok;
    assign o_st.valid = r_s1_valid;
    assign o_st.emit  = emit;
    assign o_res      = upd;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_s1_pix.col[TILE_IDX_W-1:0]] <= wr_entry;
        if (i_accept) r_rd <= mem[i_pix.col[TILE_IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (wr_en) r_vld[r_s1_pix.col[TILE_IDX_W-1:0]] <= 1'b1;
            if (i_accept)
                r_s1_valid <= 1'b1;
            else if (i_move)
                r_s1_valid <= 1'b0;
        end
    end

    // write of the item leaving stage 1 lands after this read: forward it
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_pix  <= i_pix;
            r_s1_resp <= i_resp;
            r_rd_vld  <= r_vld[i_pix.col[TILE_IDX_W-1:0]];
            r_fwd     <= wr_entry;
            r_fwd_hit <= wr_en && (r_s1_pix.col == i_pix.col);
        end
    end

endmodule

// ----- hw/rtl/tile_max_point_picker_top.sv -----
// Channel      | dir | handshake                 | payload
// pixel in     | in  | i_in_valid / o_in_stall   | i_response
// point out    | out | o_out_valid / i_out_stall | o_point_x, o_point_y, o_score
// config write | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pixel per cycle while o_in_stall is low; a tile's point goes from stage 1 into the output register.
// Rate is set by the read-modify-write of the tile-column memory (with forwarding).
// Reset is synchronous; memory entries carry valid flags, no clearing pass.
// A stalled output only holds input when the pending pixel closes a tile with a point.
// Depends on tmpp_pkg, tmpp_cfg, tmpp_scan, tmpp_tile and the defines header.
`include "tile_max_point_picker_top_defines.svh"

module tile_max_point_picker_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [15:0]             i_response,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [11:0]                    o_point_x,
    output logic [11:0]                    o_point_y,
    output logic [14:0]                    o_score,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tmpp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tmpp_pkg::DIM_W-1:0]     i_cfg_data
);
    import tmpp_pkg::*;

    t_cfg   cfg;
    t_pix   pix;
    t_s1_st st;
    t_entry res;
    t_entry r_out;
    logic   r_out_valid, n_out_valid;
    logic   accept, move, out_free, load;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign move        = !st.valid || !st.emit || out_free;
    assign o_in_stall  = !move;
    assign accept      = i_in_valid && move;
    assign load        = st.valid && st.emit && out_free;

    tmpp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tmpp_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cfg    (cfg),
        .o_pix    (pix)
    );

    tmpp_tile u_tile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pix    (pix),
        .i_resp   (i_response),
        .i_move   (move),
        .o_st     (st),
        .o_res    (res)
    );

    always_comb begin
        if (load)
            n_out_valid = 1'b1;
        else if (out_free)
            n_out_valid = 1'b0;
        else
            n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else
            r_out_valid <= n_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (load) r_out <= res;
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_out.x;
    assign o_point_y   = r_out.y;
    assign o_score     = r_out.score;

    `TMPP_ASSERT_NEXT(a_accept_fills_stage, accept, st.valid)
    `TMPP_ASSERT_NEXT(a_emit_reaches_out, load, o_out_valid && (o_score != '0))
    `TMPP_ASSERT_NEXT(a_no_repeat, o_out_valid && !i_out_stall && !load, !o_out_valid)

endmodule

// ----- sim/tile_max_point_picker_top_test.sv -----
// Testbench for tile_max_point_picker_top: streams pixels, tracks per-tile maxima in a
// local model and compares every point the block gives. Needs tmpp_pkg and the RTL only.
`timescale 1ns / 100ps

module tile_max_point_picker_top_test;
    import tmpp_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int HOLD_OFF       = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic signed [15:0]   i_response  = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_WIDTH;
    logic [DIM_W-1:0]     i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [11:0]          o_point_x;
    logic [11:0]          o_point_y;
    logic [14:0]          o_score;
    logic                 o_cfg_ready;

    tile_max_point_picker_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_response  (i_response),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_score     (o_score),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // tile tracker state
    logic [DIM_W-1:0]    cfg_width  = RESET_WIDTH;
    logic [DIM_W-1:0]    cfg_height = RESET_HEIGHT;
    logic [TILE_W-1:0]   cfg_tile   = RESET_TILE;
    logic signed [15:0]  tile_best [MAX_TILES];
    logic [POS_W-1:0]    tile_bx   [MAX_TILES];
    logic [POS_W-1:0]    tile_by   [MAX_TILES];
    logic                tile_hit  [MAX_TILES];
    logic [POS_W-1:0]    cur_x   = '0;
    logic [POS_W-1:0]    cur_y   = '0;
    logic [TPOS_W-1:0]   cur_tx  = '0;
    logic [TPOS_W-1:0]   cur_ty  = '0;
    logic [COL_W-1:0]    cur_col = '0;
    t_entry              expected_points[$];

    int in_idle_pct    = 0;
    int out_stall_pct  = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    initial begin
        for (int i = 0; i < MAX_TILES; i++) begin
            tile_best[i] = '0;
            tile_bx[i]   = '0;
            tile_by[i]   = '0;
            tile_hit[i]  = 1'b0;
        end
    end

    function automatic int last_index(input int raw, input int hi);
        if (raw < 1) return 0;
        if (raw > hi) return hi - 1;
        return raw - 1;
    endfunction

    function automatic void track_pixel(input logic signed [15:0] resp);
        int     w_last;
        int     h_last;
        int     t_last;
        bit     at_x_end;
        bit     at_y_end;
        t_entry pt;
        w_last   = last_index(int'(cfg_width), int'(DIM_MAX));
        h_last   = last_index(int'(cfg_height), int'(DIM_MAX));
        t_last   = last_index(int'(cfg_tile), int'(TILE_MAX));
        at_x_end = (int'(cur_x) >= w_last) || (int'(cur_tx) >= t_last);
        at_y_end = (int'(cur_y) >= h_last) || (int'(cur_ty) >= t_last);
        if (int'(cur_col) < MAX_TILES) begin
            if (cur_tx == 0 && cur_ty == 0) begin
                tile_hit[cur_col]  = 1'b0;
                tile_best[cur_col] = '0;
            end
            if (resp > tile_best[cur_col]) begin
                tile_best[cur_col] = resp;
                tile_bx[cur_col]   = cur_x;
                tile_by[cur_col]   = cur_y;
                tile_hit[cur_col]  = 1'b1;
            end
            if (at_x_end && at_y_end && tile_hit[cur_col]) begin
                pt.x     = tile_bx[cur_col];
                pt.y     = tile_by[cur_col];
                pt.score = tile_best[cur_col][SCORE_W-1:0];
                expected_points = {expected_points, pt};
                tile_hit[cur_col]  = 1'b0;
                tile_best[cur_col] = '0;
            end
        end
        if (int'(cur_x) >= w_last) begin
            cur_x   = '0;
            cur_tx  = '0;
            cur_col = '0;
            if (int'(cur_y) >= h_last) begin
                cur_y  = '0;
                cur_ty = '0;
            end else begin
                cur_y  = cur_y + 1'b1;
                cur_ty = (int'(cur_ty) >= t_last) ? '0 : cur_ty + 1'b1;
            end
        end else begin
            cur_x = cur_x + 1'b1;
            if (int'(cur_tx) >= t_last) begin
                cur_tx = '0;
                if (int'(cur_col) < MAX_TILES) cur_col = cur_col + 1'b1;
            end else begin
                cur_tx = cur_tx + 1'b1;
            end
        end
    endfunction

    function automatic logic signed [15:0] pick_response(input bit mostly_low);
        int sel;
        sel = $urandom_range(0, 9);
        if (mostly_low && sel < 8) return 16'(-int'($urandom_range(0, 32768)));
        case (sel)
            0, 1, 2: return 16'($urandom_range(0, 65535));
            3, 4:    return 16'(int'($urandom_range(0, 8)) - 4);
            5: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sd32767;
                    1:       return -16'sd32768;
                    2:       return 16'sd0;
                    3:       return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            default: return 16'($urandom_range(1, 32767));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic set_idling(input int in_pct, input int out_pct);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
    endtask

    task automatic send_pixel(input logic signed [15:0] resp);
        while (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_response <= resp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_pixel(resp);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
                                input logic [DIM_W-1:0] tile, input bit with_unused);
        logic [CFG_IDX_W-1:0] idx;
        logic [DIM_W-1:0]     val;
        for (int k = 0; k < (with_unused ? 4 : 3); k++) begin
            case (k)
                0:       begin idx = CFG_WIDTH;  val = width;  end
                1:       begin idx = CFG_HEIGHT; val = height; end
                2:       begin idx = CFG_TILE;   val = tile;   end
                default: begin idx = CFG_UNUSED; val = DIM_W'($urandom); end
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx)
                CFG_WIDTH:  cfg_width  = val;
                CFG_HEIGHT: cfg_height = val;
                CFG_TILE:   cfg_tile   = val[TILE_W-1:0];
                default:    ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= (out_stall_pct != 0) && ($urandom_range(0, 99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        t_entry want;
        if (o_out_valid && !i_out_stall) begin
            if (expected_points.size() == 0) begin
                report_mismatch($sformatf("unexpected point x=%0d y=%0d score=%0d",
                                          o_point_x, o_point_y, o_score));
            end else begin
                want = expected_points.pop_front();
                if (o_point_x !== want.x)
                    report_mismatch($sformatf("point_x got %0d expected %0d", o_point_x, want.x));
                if (o_point_y !== want.y)
                    report_mismatch($sformatf("point_y got %0d expected %0d", o_point_y, want.y));
                if (o_score !== want.score)
                    report_mismatch($sformatf("score got %0d expected %0d", o_score, want.score));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tile_max_point_picker_top_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // pixels at reset sizes, then a resize in the middle of the image
    task automatic test_resize_mid_image();
        set_idling(0, 0);
        repeat (5) send_pixel(16'($urandom_range(1, 32767)));
        settle();
        apply_config(13'd3, 13'd3, 13'd16, 1'b0);
        repeat (12) send_pixel(pick_response(1'b0));
    endtask

    task automatic test_single_pixel_tiles();
        settle();
        apply_config(13'd3, 13'd2, 13'd0, 1'b0);
        send_pixel(16'sd32767);
        send_pixel(-16'sd32768);
        send_pixel(16'sd0);
        send_pixel(16'sd1);
        send_pixel(-16'sd1);
        send_pixel(16'sd16384);
    endtask

    task automatic test_clamped_sizes();
        settle();
        apply_config(13'd0, 13'd0, 13'd127, 1'b1);
        send_pixel(16'sd7);
        send_pixel(-16'sd5);
    endtask

    task automatic test_ties_and_nonpositive();
        settle();
        apply_config(13'd4, 13'd1, 13'd2, 1'b0);
        send_pixel(16'sd9);
        send_pixel(16'sd9);
        send_pixel(-16'sd3);
        send_pixel(16'sd0);
    endtask

    // more tile columns than entries: the far columns are dropped
    task automatic test_column_saturation();
        settle();
        set_idling(31, 31);
        apply_config(13'd260, 13'd2, 13'd1, 1'b0);
        repeat (260) send_pixel(pick_response(1'b0));
    endtask

    task automatic test_widest_row();
        settle();
        set_idling(0, 48);
        apply_config(DIM_MAX, 13'd1, 13'(TILE_MAX), 1'b1);
        repeat (24) send_pixel(pick_response(1'b0));
    endtask

    task automatic test_tallest_column();
        settle();
        set_idling(48, 0);
        apply_config(13'd1, 13'h1FFF, {6'h3F, 7'd100}, 1'b0);
        repeat (24) send_pixel(pick_response(1'b0));
    endtask

    task automatic test_random_traffic();
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [TILE_W-1:0] tile;
        bit                mostly_low;
        int                count;
        for (int phase = 0; phase < 4; phase++) begin
            for (int seg = 0; seg < 3; seg++) begin
                settle();
                case (phase)
                    0:       set_idling(0, 0);
                    1:       set_idling(48, 0);
                    2:       set_idling(0, 48);
                    default: set_idling(31, 31);
                endcase
                width  = DIM_W'($urandom_range(0, 24));
                height = DIM_W'($urandom_range(0, 24));
                tile   = $urandom_range(0, 1) ? TILE_W'($urandom_range(16, 24))
                                              : TILE_W'($urandom_range(0, 15));
                apply_config(width, height, {6'($urandom), tile}, $urandom_range(0, 3) == 0);
                mostly_low = ($urandom_range(0, 5) == 0);
                count      = $urandom_range(4, 8);
                repeat (count) send_pixel(pick_response(mostly_low));
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_resize_mid_image();
        test_single_pixel_tiles();
        test_clamped_sizes();
        test_ties_and_nonpositive();
        test_column_saturation();
        test_widest_row();
        test_tallest_column();
        test_random_traffic();
        settle();
        if (expected_points.size() != 0)
            report_mismatch($sformatf("%0d points never arrived", expected_points.size()));
        if (mismatch_count == 0) begin
            $display("tile_max_point_picker_top_test: done, clean");
        end else begin
            $display("tile_max_point_picker_top_test: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/tmpp_pkg.sv
hw/rtl/tmpp_cfg.sv
hw/rtl/tmpp_scan.sv
hw/rtl/tmpp_tile.sv
hw/rtl/tile_max_point_picker_top.sv
sim/tile_max_point_picker_top_test.sv
